### rtl/lbek_pkg.sv
// Shared types for the LRU batch-evict key cache: controller states, command and status words.
package lbek_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_SCAN,
    ST_DRAIN,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic load_key;
    logic commit;
    logic scan_clear;
    logic scan_issue;
    logic evict_apply;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic full;
    logic scan_last;
    logic more;
    logic out_free;
  } sts_t;

endpackage

### rtl/lbek_ctrl.sv
// Controller state machine for the LRU batch-evict key cache.
module lbek_ctrl import lbek_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CMP;
      end
      ST_CMP: begin
        if (sts.hit || !sts.full) begin
          if (sts.out_free) state_next = ST_IDLE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_APPLY;
      ST_APPLY: begin
        if (sts.more) state_next = ST_SCAN;
        else state_next = ST_CMP;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load_key = in_valid;
      end
      ST_CMP: begin
        if (sts.hit || !sts.full) begin
          cmd.commit = sts.out_free;
        end else begin
          cmd.scan_clear = 1'b1;
        end
      end
      ST_SCAN: cmd.scan_issue = 1'b1;
      ST_DRAIN: ;
      ST_APPLY: begin
        cmd.evict_apply = 1'b1;
        cmd.scan_clear = sts.more;
      end
      default: ;
    endcase
  end

endmodule

### rtl/lbek_dp.sv
// Datapath for the LRU batch-evict key cache: key table, stamp memory, LRU scan, result register.
module lbek_dp import lbek_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int PRUNE_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [31:0] decl_id,
  input  logic [31:0] program_id,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        hit,
  output logic [3:0]  slot,
  output logic [2:0]  evicted_count
);

  localparam int IW    = $clog2(CAPACITY);
  localparam int LIMIT = (PRUNE_COUNT < 1) ? 1 : PRUNE_COUNT;
  localparam int EW    = $clog2(LIMIT + 1);

  logic [31:0]   key_decl;
  logic [31:0]   key_prog;
  logic [CAPACITY-1:0] valid;
  logic [31:0]   entry_decl [CAPACITY];
  logic [31:0]   entry_prog [CAPACITY];
  logic [31:0]   stamp_mem [CAPACITY];
  logic [31:0]   use_counter;

  logic [IW-1:0] cnt;
  logic          rd_vld;
  logic [IW-1:0] rd_idx;
  logic [31:0]   rd_data;
  logic          found;
  logic [IW-1:0] best_idx;
  logic [31:0]   best_stamp;
  logic [EW-1:0] evict_cnt;

  logic          match_hit;
  logic [IW-1:0] hit_idx;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] tgt_idx;
  logic [31:0]   new_stamp;
  logic          take;
  logic [31:0]   tgt_wide;
  logic [31:0]   evict_wide;

  // unique keys among valid entries, so OR-encoding the match is exact
  always_comb begin
    match_hit = 1'b0;
    hit_idx   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (valid[i] && entry_decl[i] == key_decl && entry_prog[i] == key_prog) begin
        match_hit = 1'b1;
        hit_idx   = hit_idx | IW'(i);
      end
    end
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid[i]) free_idx = IW'(i);
    end
  end

  assign tgt_idx    = match_hit ? hit_idx : free_idx;
  assign new_stamp  = use_counter + (match_hit ? 32'd1 : 32'd2);
  assign take       = rd_vld && valid[rd_idx] && (!found || rd_data < best_stamp);
  assign tgt_wide   = 32'(tgt_idx);
  assign evict_wide = 32'(evict_cnt);

  assign sts.hit       = match_hit;
  assign sts.full      = &valid;
  assign sts.scan_last = (cnt == IW'(CAPACITY - 1));
  assign sts.more      = found && (evict_wide + 32'd1 < 32'(LIMIT));
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      use_counter <= '0;
      out_valid   <= 1'b0;
      found       <= 1'b0;
      rd_vld      <= 1'b0;
      evict_cnt   <= '0;
      cnt         <= '0;
    end else begin
      rd_vld <= cmd.scan_issue;
      if (cmd.load_key) evict_cnt <= '0;
      if (cmd.scan_clear) begin
        cnt   <= '0;
        found <= 1'b0;
      end else begin
        if (cmd.scan_issue && !sts.scan_last) cnt <= cnt + 1'b1;
        if (take) found <= 1'b1;
      end
      if (cmd.evict_apply && found) begin
        valid[best_idx] <= 1'b0;
        evict_cnt       <= evict_cnt + 1'b1;
      end
      if (cmd.commit) begin
        valid[tgt_idx] <= 1'b1;
        use_counter    <= new_stamp;
      end
      if (cmd.commit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // stamp memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.commit) stamp_mem[tgt_idx] <= new_stamp;
    rd_data <= stamp_mem[cnt];
  end

  always_ff @(posedge clk) begin
    rd_idx <= cnt;
    if (cmd.load_key) begin
      key_decl <= decl_id;
      key_prog <= program_id;
    end
    if (cmd.commit && !match_hit) begin
      entry_decl[tgt_idx] <= key_decl;
      entry_prog[tgt_idx] <= key_prog;
    end
    if (take && !cmd.scan_clear) begin
      best_idx   <= rd_idx;
      best_stamp <= rd_data;
    end
    if (cmd.commit) begin
      hit           <= match_hit;
      slot          <= tgt_wide[3:0];
      evicted_count <= evict_wide[2:0];
    end
  end

  a_no_insert_full: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (match_hit || !(&valid)))
    else $error("insert into full table");

  a_evict_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.evict_apply && found) |=> !valid[$past(best_idx)])
    else $error("evicted entry still valid");

  a_hit_stamp: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && match_hit) |=> use_counter == $past(use_counter) + 32'd1)
    else $error("hit counter step wrong");

  a_miss_stamp: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !match_hit) |=> use_counter == $past(use_counter) + 32'd2)
    else $error("miss counter step wrong");

  a_evict_bound: assert property (@(posedge clk) disable iff (rst)
    32'(evict_cnt) <= 32'(LIMIT))
    else $error("eviction count over limit");

endmodule

### rtl/lru_batch_evict_key_cache.sv
// Top level of the fully associative key cache with LRU batch eviction.
// Usage:
//   Input channel in_valid/in_ready carries one lookup word (decl_id, program_id).
//   Output channel out_valid/out_ready returns one word per lookup: hit, slot and
//   evicted_count (entries dropped by this lookup).
//   A lookup is taken in the idle state and compared against all entries in the
//   next cycle. Hits and misses into a non-full table commit there once the
//   output register is free. A miss into a full table runs up to PRUNE_COUNT
//   eviction passes, each a walk of the stamp memory read port, then inserts.
//   The result sits in an output register; the next lookup is accepted while it
//   waits. If the receiver stalls and a second result is ready, the block holds
//   that lookup until the output register frees up.
//   Reset (rst, synchronous) empties the table and clears the use counter; no
//   clearing pass is needed.
module lru_batch_evict_key_cache import lbek_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int PRUNE_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] decl_id,
  input  logic [31:0] program_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [3:0]  slot,
  output logic [2:0]  evicted_count
);

  cmd_t cmd;
  sts_t sts;

  lbek_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lbek_dp #(
    .CAPACITY    (CAPACITY),
    .PRUNE_COUNT (PRUNE_COUNT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .decl_id       (decl_id),
    .program_id    (program_id),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .hit           (hit),
    .slot          (slot),
    .evicted_count (evicted_count)
  );

endmodule

### sim/tb_lru_batch_evict_key_cache.sv
// Testbench for the LRU batch-evict key cache: directed and random lookups checked against a predictor.
module tb_lru_batch_evict_key_cache;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY    = 16;
  localparam int PRUNE_COUNT = 4;
  localparam int PRUNE_LIMIT = (PRUNE_COUNT < 1) ? 1 : PRUNE_COUNT;
  localparam int RANDOM_ITEMS = 2000;
  localparam int DRAIN_CYCLES = 2 * (2 + PRUNE_LIMIT * (CAPACITY + 2)) + 20;
  localparam int CYCLE_LIMIT  = 1_500_000;

  typedef struct {
    logic [31:0] decl;
    logic [31:0] prog;
    bit          drain;
  } lookup_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] slot;
    logic [2:0] evicted;
  } lookup_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] decl_id = '0;
  logic [31:0] program_id = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        hit;
  logic [3:0]  slot;
  logic [2:0]  evicted_count;

  lookup_t        lookup_q[$];
  lookup_result_t result_exp_q[$];

  // predictor state
  bit          line_valid[CAPACITY];
  logic [31:0] line_decl[CAPACITY];
  logic [31:0] line_prog[CAPACITY];
  logic [31:0] line_stamp[CAPACITY];
  logic [31:0] use_clock = '0;

  int unsigned shown_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned word_cnt = 0;
  int unsigned error_cnt = 0;
  int unsigned cycle_cnt = 0;
  int          in_gap_left = 0;
  int          in_calm = 0;
  int          out_stall_left = 0;
  int          out_calm = 0;

  lru_batch_evict_key_cache #(
    .CAPACITY    (CAPACITY),
    .PRUNE_COUNT (PRUNE_COUNT)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .decl_id       (decl_id),
    .program_id    (program_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .slot          (slot),
    .evicted_count (evicted_count)
  );

  always #6 clk = ~clk;

  function automatic lookup_result_t predict_lookup(logic [31:0] decl, logic [31:0] prog);
    lookup_result_t res;
    int used;
    int victim;
    int target;
    int dropped;
    res = '0;
    used = 0;
    dropped = 0;
    target = 0;
    for (int s = 0; s < CAPACITY; s++) begin
      if (line_valid[s] && line_decl[s] == decl && line_prog[s] == prog) begin
        use_clock = use_clock + 32'd1;
        line_stamp[s] = use_clock;
        res.hit = 1'b1;
        res.slot = 4'(s);
        return res;
      end
      if (line_valid[s]) used++;
    end
    if (used >= CAPACITY) begin
      while (dropped < PRUNE_LIMIT) begin
        victim = -1;
        for (int s = 0; s < CAPACITY; s++) begin
          if (line_valid[s] && (victim < 0 || line_stamp[s] < line_stamp[victim])) victim = s;
        end
        if (victim < 0) break;
        line_valid[victim] = 1'b0;
        dropped++;
      end
    end
    for (int s = 0; s < CAPACITY; s++) begin
      if (!line_valid[s]) begin
        target = s;
        break;
      end
    end
    use_clock = use_clock + 32'd2;
    line_valid[target] = 1'b1;
    line_decl[target]  = decl;
    line_prog[target]  = prog;
    line_stamp[target] = use_clock;
    res.hit = 1'b0;
    res.slot = 4'(target);
    res.evicted = 3'(dropped);
    return res;
  endfunction

  // mostly short idles, a few long ones, and calm stretches with none
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 45);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_cnt < 100)
      $display("mismatch: %s at word %0d: got %0h want %0h", what, word_cnt, got, want);
    error_cnt++;
  endtask

  task automatic add_lookup(logic [31:0] decl, logic [31:0] prog, bit drain);
    lookup_t l;
    l.decl = decl;
    l.prog = prog;
    l.drain = drain;
    lookup_q.push_back(l);
  endtask

  // driver
  always @(negedge clk) begin
    lookup_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || taken_cnt == shown_cnt) begin
      if (in_gap_left > 0) begin
        in_valid <= 1'b0;
        in_gap_left <= in_gap_left - 1;
      end else if (lookup_q.size() != 0 &&
                   !(lookup_q[0].drain && result_exp_q.size() != 0)) begin
        nxt = lookup_q.pop_front();
        decl_id <= nxt.decl;
        program_id <= nxt.prog;
        in_valid <= 1'b1;
        shown_cnt <= shown_cnt + 1;
        in_gap_left <= idle_len(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_stall_left > 0) begin
      out_ready <= 1'b0;
      out_stall_left <= out_stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      out_stall_left <= idle_len(out_calm);
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (result_exp_q.size() == 0) begin
          report_mismatch("unexpected word", {hit, slot, evicted_count}, '0);
        end else begin
          want = result_exp_q.pop_front();
          if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
          if (slot !== want.slot) report_mismatch("slot", slot, want.slot);
          if (evicted_count !== want.evicted)
            report_mismatch("evicted_count", evicted_count, want.evicted);
        end
        word_cnt <= word_cnt + 1;
      end
      if (in_valid && in_ready) begin
        result_exp_q.push_back(predict_lookup(decl_id, program_id));
        taken_cnt <= taken_cnt + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [31:0] decl_pool[6];
    logic [31:0] prog_pool[6];
    int nd;
    int np;
    int seg_len;
    int kind;
    bit drain;

    // directed: extreme keys, a hit, fill to full, refresh, eviction, reuse
    add_lookup('0, '0, 1'b0);
    add_lookup('1, '1, 1'b0);
    add_lookup('0, '1, 1'b0);
    add_lookup('1, '0, 1'b0);
    add_lookup('0, '0, 1'b0);
    for (int i = 1; i <= 12; i++) add_lookup(32'(i), ~32'(i), 1'b0);
    add_lookup('1, '0, 1'b0);
    add_lookup(32'h5a5a_5a5a, 32'ha5a5_a5a5, 1'b1);
    add_lookup('0, '0, 1'b0);
    add_lookup('1, '1, 1'b0);
    add_lookup(32'd1, ~32'd1, 1'b0);
    add_lookup(32'd1, 32'd1, 1'b0);

    // random: key pools sharing halves so partial matches are common
    while (lookup_q.size() < RANDOM_ITEMS + 22) begin
      kind = $urandom_range(0, 99);
      drain = ($urandom_range(0, 9) == 0);
      if (kind < 85) begin
        if (kind < 15) begin
          nd = $urandom_range(1, 3);
          np = $urandom_range(1, 4);
        end else begin
          nd = $urandom_range(2, 6);
          np = $urandom_range(2, 6);
        end
        for (int i = 0; i < 6; i++) begin
          decl_pool[i] = $urandom();
          prog_pool[i] = $urandom();
        end
        seg_len = $urandom_range(20, 80);
        for (int i = 0; i < seg_len; i++)
          add_lookup(decl_pool[$urandom_range(0, nd - 1)],
                     prog_pool[$urandom_range(0, np - 1)], drain && i == 0);
      end else begin
        seg_len = $urandom_range(5, 30);
        for (int i = 0; i < seg_len; i++)
          add_lookup($urandom(), $urandom(), drain && i == 0);
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (lookup_q.size() != 0 || in_valid) @(posedge clk);
    while (result_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
